@@ sv/tsm_pkg.sv @@
// tsm_pkg: shared types and constants of the sliding window trimmed mean unit
// no dependencies
package tsm_pkg;

  localparam int SAMPLE_W  = 17;
  localparam int WLEN_W    = 7;
  localparam int TRIM_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;
  localparam int WLEN_MIN  = 3;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd64;
  localparam logic [TRIM_W-1:0] TRIM_RESET = 5'd1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT    = 2'd1;

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOADI = 7'b0000010,
    S_LATCH = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_ACC   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

endpackage

@@ sv/tsm_in_if.sv @@
// tsm_in_if: input channel carrying one sample per item
// depends on tsm_pkg
interface tsm_in_if import tsm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ sv/tsm_out_if.sv @@
// tsm_out_if: result channel carrying valid flag and trimmed mean
// depends on tsm_pkg
interface tsm_out_if import tsm_pkg::*; ();
  logic    valid;
  logic    ready;
  logic    valid_res;
  sample_t average;

  modport source (output valid, output valid_res, output average, input ready);
  modport sink (input valid, input valid_res, input average, output ready);
endinterface

@@ sv/tsm_ram.sv @@
// tsm_ram: generic single write port, single read port ram with registered read
// no dependencies
module tsm_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/tsm_div.sv @@
// tsm_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies
module tsm_div #(
  parameter int NW = 24,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem;
  logic [DW-1:0]    dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem, quotient[NW-1]};
  assign fits  = trial >= {1'b0, dsr};

  // shift and subtract loop
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? DW'(trial - {1'b0, dsr}) : trial[DW-1:0];
      quotient <= {quotient[NW-2:0], fits};
    end
  end

endmodule

@@ sv/sliding_window_trimmed_mean_unit.sv @@
// Sliding window trimmed mean: each sample item is written into a ring memory and
// answered by one result item. The window is the last window_length samples,
// clamped to WLEN_MIN..WINDOW_MAX; the trim_count smallest and largest, trim
// capped below half the window, are dropped, the rest averaged with truncation.
// For a valid result the run time is set by the rank scan: every window entry is
// compared against every other through the single read port of the ring, followed
// by a bit-serial divide. One item is processed at a time.
// depends on tsm_pkg, tsm_in_if, tsm_out_if, tsm_ram, tsm_div
module sliding_window_trimmed_mean_unit import tsm_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  tsm_in_if.sink                samples,
  tsm_out_if.source             results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW    = $clog2(WINDOW_MAX);
  localparam int CW    = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_W + CW;
  localparam int XW    = AW + 2;

  state_t state;

  logic [WLEN_W-1:0] wlen;
  logic [TRIM_W-1:0] trim;
  logic [AW-1:0]     wp;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     m_r;
  logic [CW-1:0]     t_r;
  logic [CW-1:0]     i_idx;
  logic [CW-1:0]     jr;
  logic [CW-1:0]     jp;
  logic [CW-1:0]     cnt;
  sample_t           vi;
  logic [SUM_W-1:0]  sum;
  logic              res_vld;
  sample_t           res_avg;

  logic [CW-1:0]     m_eff;
  logic [CW-1:0]     t_eff;
  logic [CW-1:0]     fill_inc;
  logic [AW-1:0]     wp_next;
  logic              accept;
  logic [CW-1:0]     rd_idx;
  logic [AW-1:0]     raddr;
  logic [XW-1:0]     addr_tmp;
  sample_t           rdata;
  logic              less;
  logic [CW-1:0]     cnt_upd;
  logic              kept;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  quotient;
  logic [CW-1:0]     keep;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= WLEN_RESET;
      trim <= TRIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW_LENGTH) begin
        wlen <= cfg_data[WLEN_W-1:0];
      end else if (cfg_index == REG_TRIM_COUNT) begin
        trim <= cfg_data[TRIM_W-1:0];
      end
    end
  end

  // effective window and trim
  always_comb begin
    int mi;
    int ti;
    mi = int'(wlen);
    if (mi < WLEN_MIN) mi = WLEN_MIN;
    if (mi > WINDOW_MAX) mi = WINDOW_MAX;
    ti = int'(trim);
    if (2 * ti >= mi) ti = (mi - 1) / 2;
    m_eff = CW'(mi);
    t_eff = CW'(ti);
  end

  assign accept   = samples.valid && samples.ready;
  assign samples.ready = (state == S_IDLE);
  assign fill_inc = (fill < CW'(WINDOW_MAX)) ? fill + 1'b1 : fill;
  assign wp_next  = (wp == AW'(WINDOW_MAX - 1)) ? '0 : wp + 1'b1;

  // window entry e sits at wp - 1 - e modulo the ring depth
  always_comb begin
    case (state)
      S_LOADI: rd_idx = i_idx;
      S_LATCH: rd_idx = '0;
      default: rd_idx = jr;
    endcase
    addr_tmp = XW'(wp) + XW'(WINDOW_MAX - 1) - XW'(rd_idx);
    if (addr_tmp >= XW'(WINDOW_MAX)) addr_tmp = addr_tmp - XW'(WINDOW_MAX);
    raddr = addr_tmp[AW-1:0];
  end

  tsm_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (samples.sample),
    .raddr (raddr),
    .rdata (rdata)
  );

  // rank compare with index tie break
  assign less    = (rdata < vi) || ((rdata == vi) && (jp < i_idx));
  assign cnt_upd = cnt + CW'(less);
  assign keep    = m_r - (t_r << 1);
  assign kept    = (cnt >= t_r) && (cnt < m_r - t_r);
  assign div_start = (state == S_ACC) && (i_idx == m_r - 1'b1);

  tsm_div #(.NW(SUM_W), .DW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (kept ? sum + SUM_W'(vi) : sum),
    .divisor  (keep),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      wp            <= '0;
      fill          <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready && (state != S_FIN)) results.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            wp   <= wp_next;
            fill <= fill_inc;
            state <= (fill_inc < m_eff) ? S_FIN : S_LOADI;
          end
        end
        S_LOADI: state <= S_LATCH;
        S_LATCH: state <= S_SCAN;
        S_SCAN:  if (jr == m_r) state <= S_ACC;
        S_ACC:   state <= (i_idx == m_r - 1'b1) ? S_DIV : S_LOADI;
        S_DIV:   if (div_done) state <= S_FIN;
        S_FIN: begin
          if (!results.valid || results.ready) begin
            results.valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        m_r     <= m_eff;
        t_r     <= t_eff;
        i_idx   <= '0;
        sum     <= '0;
        res_vld <= 1'b0;
        res_avg <= '0;
      end
      S_LATCH: begin
        vi  <= rdata;
        jr  <= CW'(1);
        jp  <= '0;
        cnt <= '0;
      end
      S_SCAN: begin
        cnt <= cnt_upd;
        jp  <= jr;
        if (jr != m_r) jr <= jr + 1'b1;
      end
      S_ACC: begin
        if (kept) sum <= sum + SUM_W'(vi);
        i_idx <= i_idx + 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          res_vld <= 1'b1;
          res_avg <= quotient[SAMPLE_W-1:0];
        end
      end
      S_FIN: begin
        if (!results.valid || results.ready) begin
          results.valid_res <= res_vld;
          results.average   <= res_avg;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    accept |=> !samples.ready)
    else $error("item accepted while previous item in flight");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(WINDOW_MAX))
    else $error("fill count beyond ring depth");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !res_vld |-> res_avg == '0)
    else $error("not valid result carries nonzero average");

  a_keep_positive: assert property (@(posedge clk) disable iff (rst)
    div_start |-> keep != '0)
    else $error("divide by zero kept count");

endmodule

@@ sim/sliding_window_trimmed_mean_unit_tb.sv @@
// testbench for sliding_window_trimmed_mean_unit: random and directed samples
// with a built-in trimmed mean predictor; depends on tsm_pkg, tsm_in_if, tsm_out_if
`timescale 1ns / 100ps

module sliding_window_trimmed_mean_unit_tb;
  import tsm_pkg::*;

  localparam int RING_DEPTH = 64;

  typedef struct packed {
    logic    valid_res;
    sample_t average;
  } mean_result_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tsm_in_if  in_ch();
  tsm_out_if out_ch();

  sliding_window_trimmed_mean_unit dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (in_ch),
    .results   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state
  sample_t          ring_mem [RING_DEPTH];
  logic [5:0]       wr_pos = '0;
  logic [6:0]       seen_count = '0;
  logic [WLEN_W-1:0] win_len = WLEN_RESET;
  logic [TRIM_W-1:0] trim = TRIM_RESET;

  sample_t      pending_samples[$];
  mean_result_t expected_means[$];
  int  errors = 0;
  logic in_fire = 1'b0;
  logic quiet = 1'b0;
  int  send_gap = 0;
  int  recv_stall = 0;
  int  hold_reqs = 0;
  int  hold_served = 0;

  // append one sample to the pending queue
  function automatic void add_pending(sample_t s);
    pending_samples = {pending_samples, s};
  endfunction

  // store the sample, then work out the trimmed mean of the window
  function automatic mean_result_t trimmed_mean_of(sample_t s);
    mean_result_t r;
    sample_t win [RING_DEPTH];
    sample_t v;
    int m, t, keep, j, p;
    int unsigned sum;
    ring_mem[wr_pos] = s;
    wr_pos = wr_pos + 6'd1;
    if (seen_count < 7'(RING_DEPTH)) seen_count = seen_count + 7'd1;
    m = int'(win_len);
    if (m < WLEN_MIN) m = WLEN_MIN;
    if (m > RING_DEPTH) m = RING_DEPTH;
    r = '0;
    if (int'(seen_count) >= m) begin
      t = int'(trim);
      if (2 * t >= m) t = (m - 1) / 2;
      p = int'(wr_pos);
      for (int i = 0; i < m; i++) begin
        p = (p == 0) ? RING_DEPTH - 1 : p - 1;
        win[i] = ring_mem[p];
      end
      // insertion sort, ascending
      for (int i = 1; i < m; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      keep = m - 2 * t;
      sum = 0;
      for (int i = t; i < t + keep; i++) sum += win[i];
      r.valid_res = 1'b1;
      r.average = sample_t'(sum / keep);
    end
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // sample driver, inputs change on the falling edge
  always @(negedge clk) begin
    logic    nxt_v;
    sample_t nxt_s;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
    end else if (!in_ch.valid || in_fire) begin
      nxt_v = 1'b0;
      nxt_s = in_ch.sample;
      if (send_gap > 0) begin
        send_gap--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(1, 17) - 1;
      end else if (pending_samples.size() > 0) begin
        nxt_v = 1'b1;
        nxt_s = pending_samples.pop_front();
      end
      in_ch.valid <= nxt_v;
      in_ch.sample <= nxt_s;
    end
  end

  // result ready, with random stalls and the occasional long hold-off
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (hold_reqs != hold_served) begin
      hold_served++;
      recv_stall = 400;
    end
    if (rst) begin
      rdy = 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(1, 17) - 1;
      rdy = 1'b0;
    end
    out_ch.ready <= rdy;
  end

  // monitor: predict on accepted samples, check accepted results
  always @(posedge clk) begin
    mean_result_t exp_r;
    mean_result_t exp_n;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        exp_n = trimmed_mean_of(in_ch.sample);
        expected_means = {expected_means, exp_n};
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result valid_res=%0d average=%0d", $time,
                   out_ch.valid_res, out_ch.average);
          errors++;
        end else begin
          exp_r = expected_means.pop_front();
          if (out_ch.valid_res !== exp_r.valid_res) begin
            $display("%0t: valid_res expected %0d actual %0d", $time,
                     exp_r.valid_res, out_ch.valid_res);
            errors++;
          end
          if (out_ch.average !== exp_r.average) begin
            $display("%0t: average expected %0d actual %0d", $time,
                     exp_r.average, out_ch.average);
            errors++;
          end
        end
      end
    end
  end

  // wait until every sample is taken and every result is back
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (pending_samples.size() > 0 || in_ch.valid || expected_means.size() > 0);
    repeat (10) @(negedge clk);
  endtask

  // register write, mirrored into the predictor
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_WINDOW_LENGTH) win_len = val[WLEN_W-1:0];
    else if (idx == REG_TRIM_COUNT) trim = val[TRIM_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return sample_t'($urandom_range(0, 15));
      3: return sample_t'($urandom_range(131000, 131071));
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic run_phase(logic [CFG_DATA_W-1:0] wl, logic [CFG_DATA_W-1:0] tr, int n);
    write_reg(REG_WINDOW_LENGTH, wl);
    write_reg(REG_TRIM_COUNT, tr);
    for (int i = 0; i < n; i++) add_pending(pick_sample());
    drain();
  endtask

  // stimulus and end of run
  initial begin
    int wl;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: fill the full window, a few valid results
    for (int i = 0; i < 68; i++) add_pending(pick_sample());
    drain();

    // directed: extremes with no trim on the smallest window
    write_reg(REG_WINDOW_LENGTH, 7'd3);
    write_reg(REG_TRIM_COUNT, 7'd0);
    pending_samples = '{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h0, 17'h0, 17'h0,
                        17'h1, 17'h1FFFF, 17'h2, 17'h15555, 17'h0AAAA};
    drain();
    // trim too large, window too small, window too large, bad indexes
    run_phase(7'd3, 7'd31, 4);
    run_phase(7'd0, 7'd1, 3);
    run_phase(7'd127, 7'd31, 3);
    write_reg(2'd2, 7'd5);
    write_reg(2'd3, 7'd9);
    run_phase(7'd64, 7'd0, 2);

    // long receiver hold-off while the sender keeps offering
    write_reg(REG_WINDOW_LENGTH, 7'd3);
    hold_reqs++;
    for (int i = 0; i < 40; i++) add_pending(pick_sample());
    drain();

    // random phases, mostly small windows
    for (int ph = 0; ph < 20; ph++) begin
      if (ph >= 17) quiet = 1'b1;
      wl = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 20) : $urandom_range(3, 8);
      if ($urandom_range(0, 4) == 0) write_reg(CFG_IDX_W'($urandom_range(2, 3)), 7'($urandom));
      run_phase(7'(wl), 7'($urandom_range(0, 127)), 68);
    end

    repeat (50) @(negedge clk);
    if (errors == 0 && expected_means.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // run limit
  initial begin
    #16000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sliding_window_trimmed_mean_unit.f @@
sv/tsm_pkg.sv
sv/tsm_in_if.sv
sv/tsm_out_if.sv
sv/tsm_ram.sv
sv/tsm_div.sv
sv/sliding_window_trimmed_mean_unit.sv
sim/sliding_window_trimmed_mean_unit_tb.sv
